// ===== rtl/bpr_factor_sgd_step_macros.svh =====
// assertion macros shared by the checker of the ranking sgd block
// no dependencies; take in by include
`ifndef BPR_FACTOR_SGD_STEP_MACROS_SVH
`define BPR_FACTOR_SGD_STEP_MACROS_SVH

// implication checked in the same cycle, quiet during reset
`define BFS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// implication checked in the next cycle, quiet during reset
`define BFS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

// checked in the next cycle, also live while reset is asserted
`define BFS_ASSERT_RAW(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== rtl/bfs_pkg.sv =====
// constants, codes and arithmetic helpers of the ranking sgd block
// no dependencies
package bfs_pkg;

   localparam int NUM_USERS = 1024;
   localparam int NUM_ITEMS = 4096;
   localparam int RANK      = 32;

   localparam int LANE_W    = $clog2(RANK);
   localparam int USER_W    = $clog2(NUM_USERS);
   localparam int ITEM_W    = $clog2(NUM_ITEMS);
   localparam int UADDR_W   = USER_W + LANE_W;
   localparam int IADDR_W   = ITEM_W + LANE_W;

   localparam int FACT_W    = 16;
   localparam int CFG_W     = 16;
   localparam int SIG_W     = 17;
   localparam int MUL_A_W   = 36;
   localparam int MUL_B_W   = 18;
   localparam int PROD_W    = MUL_A_W + MUL_B_W;
   localparam int ACC_W     = 32 + $clog2(RANK) + 2;
   localparam int SCORE_W   = 32;

   localparam logic [1:0] OP_TRAIN     = 2'd0;
   localparam logic [1:0] OP_SCORE     = 2'd1;
   localparam logic [1:0] OP_LOAD_USER = 2'd2;
   localparam logic [1:0] OP_LOAD_ITEM = 2'd3;

   localparam logic [1:0] CSR_LRATE    = 2'd0;
   localparam logic [1:0] CSR_UREG     = 2'd1;
   localparam logic [1:0] CSR_IREG     = 2'd2;

   // 1/(1+e^x) in q16 over half-unit segments of [-8,8)
   function automatic logic [SIG_W-1:0] sig_table(input logic [4:0] idx);
      logic [SIG_W-1:0] v;
      case (idx)
         5'd0:  v = 17'd65514;
         5'd1:  v = 17'd65500;
         5'd2:  v = 17'd65476;
         5'd3:  v = 17'd65438;
         5'd4:  v = 17'd65374;
         5'd5:  v = 17'd65269;
         5'd6:  v = 17'd65097;
         5'd7:  v = 17'd64816;
         5'd8:  v = 17'd64357;
         5'd9:  v = 17'd63615;
         5'd10: v = 17'd62428;
         5'd11: v = 17'd60565;
         5'd12: v = 17'd57724;
         5'd13: v = 17'd53581;
         5'd14: v = 17'd47911;
         5'd15: v = 17'd40793;
         5'd16: v = 17'd32768;
         5'd17: v = 17'd24743;
         5'd18: v = 17'd17625;
         5'd19: v = 17'd11955;
         5'd20: v = 17'd7812;
         5'd21: v = 17'd4971;
         5'd22: v = 17'd3108;
         5'd23: v = 17'd1921;
         5'd24: v = 17'd1179;
         5'd25: v = 17'd720;
         5'd26: v = 17'd439;
         5'd27: v = 17'd267;
         5'd28: v = 17'd162;
         5'd29: v = 17'd98;
         5'd30: v = 17'd60;
         5'd31: v = 17'd36;
         default: v = 17'd36;
      endcase
      return v;
   endfunction

   // clip x (q24) to [-8,8) and pick the segment
   function automatic logic [SIG_W-1:0] sig_lookup(input logic signed [ACC_W-1:0] x);
      logic signed [ACC_W-1:0] lim;
      logic signed [ACC_W-1:0] sh;
      logic [SIG_W-1:0] v;
      lim = ACC_W'(134217728);
      sh  = x + lim;
      if (x < -lim) begin
         v = sig_table(5'd0);
      end else if (x >= lim) begin
         v = sig_table(5'd31);
      end else begin
         v = sig_table(sh[27:23]);
      end
      return v;
   endfunction

   function automatic logic signed [SCORE_W-1:0] sat32(input logic signed [ACC_W-1:0] x);
      logic signed [SCORE_W-1:0] v;
      if (&x[ACC_W-1:SCORE_W-1] || ~|x[ACC_W-1:SCORE_W-1]) begin
         v = x[SCORE_W-1:0];
      end else if (x[ACC_W-1]) begin
         v = 32'sh8000_0000;
      end else begin
         v = 32'sh7fff_ffff;
      end
      return v;
   endfunction

   // base + round half up of a q44 step to q12, saturated to a factor
   function automatic logic signed [FACT_W-1:0] upd_factor(
      input logic signed [FACT_W-1:0] base,
      input logic signed [PROD_W-1:0] prod);
      logic signed [PROD_W:0] r;
      logic signed [PROD_W-32:0] d;
      logic signed [PROD_W-31:0] sum;
      logic signed [FACT_W-1:0] v;
      r   = (PROD_W+1)'(prod) + ((PROD_W+1)'(1) <<< 31);
      d   = r[PROD_W:32];
      sum = (PROD_W-30)'(base) + (PROD_W-30)'(d);
      if (sum > (PROD_W-30)'(32767)) begin
         v = 16'sh7fff;
      end else if (sum < -(PROD_W-30)'(32768)) begin
         v = 16'sh8000;
      end else begin
         v = sum[FACT_W-1:0];
      end
      return v;
   endfunction

endpackage

// ===== rtl/bfs_ram.sv =====
// single port factor memory with registered read data
// no dependencies
module bfs_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 16
) (
   input  logic                     clock,
   input  logic                     write_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (write_en) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end

endmodule

// ===== rtl/bfs_mul.sv =====
// shared signed multiplier with a registered product
// depends on bfs_pkg
module bfs_mul import bfs_pkg::*; (
   input  logic                        clock,
   input  logic signed [MUL_A_W-1:0]   mul_a,
   input  logic signed [MUL_B_W-1:0]   mul_b,
   output logic signed [PROD_W-1:0]    prod_ff
);

   logic signed [PROD_W-1:0] prod_in;

   assign prod_in = PROD_W'(mul_a) * PROD_W'(mul_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

// ===== rtl/bpr_factor_sgd_step.sv =====
// top level of the ranking sgd block: sequencer, datapath and factor memories
// depends on bfs_pkg, bfs_ram, bfs_mul
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/req_stall | opcode, user, items, lane, load value
//   rsp     | out       | rsp_valid/rsp_stall | score, op_done
//   csr     | in        | csr_write           | csr_index, csr_data
//
// train runs the two dot products lane by lane, a sigmoid step, then the updates lane by lane
// (one multiplier, one item memory port), then a done state that hands off the result.
// score runs the dot product and the sigmoid step, then hands off; a load writes at acceptance.
// one item at a time; req_stall is high from acceptance until its result is registered.
// a held result on rsp does not stop the next item from being accepted, but that
// item waits in its hand-off cycle until the held result is taken.
// reset is synchronous; factor memories are not cleared.
module bpr_factor_sgd_step import bfs_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [1:0]                  req_opcode,
   input  logic [9:0]                  req_user_index,
   input  logic [11:0]                 req_item_pos,
   input  logic [11:0]                 req_item_neg,
   input  logic [4:0]                  req_lane_index,
   input  logic signed [15:0]          req_load_value,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic signed [SCORE_W-1:0]   rsp_score,
   output logic [1:0]                  rsp_op_done,
   input  logic                        csr_write,
   input  logic [1:0]                  csr_index,
   input  logic [CFG_W-1:0]            csr_data
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_DOT  = 3'd1;
   localparam logic [2:0] ST_SIG  = 3'd2;
   localparam logic [2:0] ST_UPD  = 3'd3;
   localparam logic [2:0] ST_DONE = 3'd4;

   // update steps of one lane
   localparam logic [3:0] U_RD_UI   = 4'd0;
   localparam logic [3:0] U_RD_J    = 4'd1;
   localparam logic [3:0] U_GET_J   = 4'd2;
   localparam logic [3:0] U_M_SD    = 4'd3;
   localparam logic [3:0] U_M_RUP   = 4'd4;
   localparam logic [3:0] U_M_SP    = 4'd5;
   localparam logic [3:0] U_M_LRP   = 4'd6;
   localparam logic [3:0] U_M_RII   = 4'd7;
   localparam logic [3:0] U_WR_U    = 4'd8;
   localparam logic [3:0] U_M_LRI   = 4'd9;
   localparam logic [3:0] U_M_LRJ   = 4'd10;
   localparam logic [3:0] U_WR_I    = 4'd11;
   localparam logic [3:0] U_WR_J    = 4'd12;

   // dot product steps of one lane
   localparam logic [3:0] D_RD_UI   = 4'd0;
   localparam logic [3:0] D_M_I     = 4'd1;
   localparam logic [3:0] D_M_J     = 4'd2;
   localparam logic [3:0] D_ACC_J   = 4'd3;

   logic [2:0]                 state_ff, state_in;
   logic [3:0]                 step_ff, step_in;
   logic [LANE_W-1:0]          k_ff, k_in;
   logic [1:0]                 op_ff, op_in;
   logic [USER_W-1:0]          u_ff, u_in;
   logic [ITEM_W-1:0]          i_ff, i_in;
   logic [ITEM_W-1:0]          j_ff, j_in;
   logic [CFG_W-1:0]           lr_ff, lr_in;
   logic [CFG_W-1:0]           ru_ff, ru_in;
   logic [CFG_W-1:0]           ri_ff, ri_in;
   logic signed [ACC_W-1:0]    acc_ff, acc_in;
   logic [SIG_W-1:0]           s_ff, s_in;
   logic signed [SCORE_W-1:0]  score_ff, score_in;
   logic signed [FACT_W-1:0]   pv_ff, pv_in;
   logic signed [FACT_W-1:0]   iv_ff, iv_in;
   logic signed [FACT_W-1:0]   jv_ff, jv_in;
   logic signed [FACT_W-1:0]   np_ff, np_in;
   logic signed [FACT_W-1:0]   ni_ff, ni_in;
   logic signed [FACT_W-1:0]   nj_ff, nj_in;
   logic signed [MUL_A_W-1:0]  t_ff, t_in;
   logic signed [MUL_A_W-1:0]  t2_ff, t2_in;
   logic signed [MUL_A_W-1:0]  m4_ff, m4_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [SCORE_W-1:0]  rsp_score_ff, rsp_score_in;
   logic [1:0]                 rsp_op_ff, rsp_op_in;

   logic                       accept;
   logic                       last_lane;
   logic                       u_we, i_we;
   logic [UADDR_W-1:0]         u_addr;
   logic [IADDR_W-1:0]         i_addr;
   logic [FACT_W-1:0]          u_wd, i_wd, u_rdata, i_rdata;
   logic signed [FACT_W-1:0]   u_rd, i_rd;
   logic signed [MUL_A_W-1:0]  mul_a;
   logic signed [MUL_B_W-1:0]  mul_b;
   logic signed [PROD_W-1:0]   prod;
   logic signed [MUL_A_W-1:0]  prod_a;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign last_lane = (k_ff == LANE_W'(RANK - 1));
   assign u_rd      = $signed(u_rdata);
   assign i_rd      = $signed(i_rdata);
   assign prod_a    = MUL_A_W'(prod);

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_score   = rsp_score_ff;
   assign rsp_op_done = rsp_op_ff;

   bfs_ram #(.DEPTH(NUM_USERS * RANK), .WIDTH(FACT_W)) u_user_mem (
      .clock    (clock),
      .write_en (u_we),
      .addr     (u_addr),
      .wdata    (u_wd),
      .rdata    (u_rdata)
   );

   bfs_ram #(.DEPTH(NUM_ITEMS * RANK), .WIDTH(FACT_W)) u_item_mem (
      .clock    (clock),
      .write_en (i_we),
      .addr     (i_addr),
      .wdata    (i_wd),
      .rdata    (i_rdata)
   );

   bfs_mul u_mul (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .prod_ff (prod)
   );

   always_comb begin
      lr_in = lr_ff;
      ru_in = ru_ff;
      ri_in = ri_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_LRATE: lr_in = csr_data;
            CSR_UREG:  ru_in = csr_data;
            CSR_IREG:  ri_in = csr_data;
            default:   ;
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      k_in     = k_ff;
      op_in    = op_ff;
      u_in     = u_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      acc_in   = acc_ff;
      s_in     = s_ff;
      score_in = score_ff;
      pv_in    = pv_ff;
      iv_in    = iv_ff;
      jv_in    = jv_ff;
      np_in    = np_ff;
      ni_in    = ni_ff;
      nj_in    = nj_ff;
      t_in     = t_ff;
      t2_in    = t2_ff;
      m4_in    = m4_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_score_in = rsp_score_ff;
      rsp_op_in    = rsp_op_ff;
      u_addr = {u_ff, k_ff};
      i_addr = {i_ff, k_ff};
      u_we   = 1'b0;
      i_we   = 1'b0;
      u_wd   = np_ff;
      i_wd   = ni_ff;
      mul_a  = '0;
      mul_b  = '0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in    = req_opcode;
               u_in     = req_user_index[USER_W-1:0];
               i_in     = req_item_pos[ITEM_W-1:0];
               j_in     = req_item_neg[ITEM_W-1:0];
               acc_in   = '0;
               k_in     = '0;
               step_in  = '0;
               score_in = '0;
               case (req_opcode)
                  OP_TRAIN, OP_SCORE: begin
                     state_in = ST_DOT;
                  end
                  OP_LOAD_USER: begin
                     u_addr   = {req_user_index[USER_W-1:0], req_lane_index[LANE_W-1:0]};
                     u_wd     = req_load_value;
                     u_we     = (int'(req_lane_index) < RANK);
                     state_in = ST_DONE;
                  end
                  default: begin
                     i_addr   = {req_item_pos[ITEM_W-1:0], req_lane_index[LANE_W-1:0]};
                     i_wd     = req_load_value;
                     i_we     = (int'(req_lane_index) < RANK);
                     state_in = ST_DONE;
                  end
               endcase
            end
         end

         ST_DOT: begin
            case (step_ff)
               D_RD_UI: begin
                  step_in = D_M_I;
               end
               D_M_I: begin
                  pv_in   = u_rd;
                  mul_a   = MUL_A_W'(i_rd);
                  mul_b   = MUL_B_W'(u_rd);
                  i_addr  = {j_ff, k_ff};
                  step_in = D_M_J;
               end
               D_M_J: begin
                  acc_in  = acc_ff + ACC_W'(prod);
                  mul_a   = MUL_A_W'(i_rd);
                  mul_b   = MUL_B_W'(pv_ff);
                  step_in = D_ACC_J;
               end
               default: begin
                  if (op_ff == OP_TRAIN) begin
                     acc_in = acc_ff - ACC_W'(prod);
                  end
                  step_in = D_RD_UI;
                  if (last_lane) begin
                     k_in     = '0;
                     state_in = ST_SIG;
                  end else begin
                     k_in = k_ff + 1'b1;
                  end
               end
            endcase
         end

         ST_SIG: begin
            s_in     = sig_lookup(acc_ff);
            score_in = sat32(acc_ff);
            step_in  = U_RD_UI;
            state_in = (op_ff == OP_TRAIN) ? ST_UPD : ST_DONE;
         end

         ST_UPD: begin
            case (step_ff)
               U_RD_UI: begin
                  step_in = U_RD_J;
               end
               U_RD_J: begin
                  pv_in   = u_rd;
                  iv_in   = i_rd;
                  i_addr  = {j_ff, k_ff};
                  step_in = U_GET_J;
               end
               U_GET_J: begin
                  jv_in   = i_rd;
                  step_in = U_M_SD;
               end
               U_M_SD: begin
                  mul_a   = MUL_A_W'(iv_ff) - MUL_A_W'(jv_ff);
                  mul_b   = $signed({1'b0, s_ff});
                  step_in = U_M_RUP;
               end
               U_M_RUP: begin
                  t_in    = prod_a;
                  mul_a   = MUL_A_W'(pv_ff);
                  mul_b   = $signed({2'b0, ru_ff});
                  step_in = U_M_SP;
               end
               U_M_SP: begin
                  t_in    = t_ff - prod_a;
                  mul_a   = MUL_A_W'(pv_ff);
                  mul_b   = $signed({1'b0, s_ff});
                  step_in = U_M_LRP;
               end
               U_M_LRP: begin
                  m4_in   = prod_a;
                  mul_a   = t_ff;
                  mul_b   = $signed({2'b0, lr_ff});
                  step_in = U_M_RII;
               end
               U_M_RII: begin
                  np_in   = upd_factor(pv_ff, prod);
                  mul_a   = MUL_A_W'(iv_ff);
                  mul_b   = $signed({2'b0, ri_ff});
                  step_in = U_WR_U;
               end
               U_WR_U: begin
                  u_we    = 1'b1;
                  t_in    = m4_ff - prod_a;
                  mul_a   = MUL_A_W'(jv_ff);
                  mul_b   = $signed({2'b0, ri_ff});
                  step_in = U_M_LRI;
               end
               U_M_LRI: begin
                  t2_in   = -m4_ff - prod_a;
                  mul_a   = t_ff;
                  mul_b   = $signed({2'b0, lr_ff});
                  step_in = U_M_LRJ;
               end
               U_M_LRJ: begin
                  ni_in   = upd_factor(iv_ff, prod);
                  mul_a   = t2_ff;
                  mul_b   = $signed({2'b0, lr_ff});
                  step_in = U_WR_I;
               end
               U_WR_I: begin
                  i_we    = 1'b1;
                  // same item twice: the negative step lands on the fresh positive value
                  nj_in   = upd_factor((i_ff == j_ff) ? ni_ff : jv_ff, prod);
                  step_in = U_WR_J;
               end
               default: begin
                  i_addr  = {j_ff, k_ff};
                  i_wd    = nj_ff;
                  i_we    = 1'b1;
                  step_in = U_RD_UI;
                  if (last_lane) begin
                     k_in     = '0;
                     state_in = ST_DONE;
                  end else begin
                     k_in = k_ff + 1'b1;
                  end
               end
            endcase
         end

         default: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_score_in = score_ff;
               rsp_op_in    = op_ff;
               state_in     = ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
         lr_ff        <= 16'd3277;
         ru_ff        <= 16'd655;
         ri_ff        <= 16'd655;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
         lr_ff        <= lr_in;
         ru_ff        <= ru_in;
         ri_ff        <= ri_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      u_ff         <= u_in;
      i_ff         <= i_in;
      j_ff         <= j_in;
      acc_ff       <= acc_in;
      s_ff         <= s_in;
      score_ff     <= score_in;
      pv_ff        <= pv_in;
      iv_ff        <= iv_in;
      jv_ff        <= jv_in;
      np_ff        <= np_in;
      ni_ff        <= ni_in;
      nj_ff        <= nj_in;
      t_ff         <= t_in;
      t2_ff        <= t2_in;
      m4_ff        <= m4_in;
      rsp_score_ff <= rsp_score_in;
      rsp_op_ff    <= rsp_op_in;
   end

endmodule

// ===== rtl/bfs_checker.sv =====
// port level checks of the ranking sgd block, bound to the top level
// depends on bfs_pkg and bpr_factor_sgd_step_macros.svh
`include "bpr_factor_sgd_step_macros.svh"

module bfs_checker import bfs_pkg::*; (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_stall,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input logic signed [SCORE_W-1:0]  rsp_score,
   input logic [1:0]                 rsp_op_done
);

   logic req_accept;
   logic rsp_held;
   logic rsp_is_load;

   assign req_accept  = req_valid && !req_stall;
   assign rsp_held    = rsp_valid && rsp_stall;
   assign rsp_is_load = rsp_op_done inside {OP_LOAD_USER, OP_LOAD_ITEM};

   // an accepted item keeps the block busy for at least the next cycle
   `BFS_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_accept, req_stall)

   // a result waiting on a stall stays
   `BFS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_held, rsp_valid && $stable(rsp_score))

   // loads report a zero score
   `BFS_ASSERT_NOW(a_load_zero, clock, reset, rsp_valid && rsp_is_load, rsp_score == 0)

   // reset leaves no result behind and the block ready
   `BFS_ASSERT_RAW(a_reset_clear, clock, reset, !rsp_valid && !req_stall)

endmodule

bind bpr_factor_sgd_step bfs_checker u_bfs_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_score   (rsp_score),
   .rsp_op_done (rsp_op_done)
);
